### rtl/tkm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkm_pkg: shared types and constants of the top-K magnitude tracker
// Request/result structs, register indexes, slot record and magnitude helper.
// ----------------------------------------------------------------------------
package tkm_pkg;

  localparam int VALUE_W = 32;
  localparam int TAG_W   = 10;
  localparam int SLOT_W  = 6;
  localparam int MAG_W   = VALUE_W + 1;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PRINT_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INSERT_MARGIN   = 1'd1;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_READOUT = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
    logic [TAG_W-1:0]          row_index;
    logic [TAG_W-1:0]          col_index;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic [TAG_W-1:0]          row_out;
    logic [TAG_W-1:0]          col_out;
    logic [SLOT_W-1:0]         slot;
    logic                      shown;
    logic                      last;
  } out_rsp_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [TAG_W-1:0]          row;
    logic [TAG_W-1:0]          col;
  } slot_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  // |v| at one extra bit so the most negative value needs no saturation
  function automatic logic [MAG_W-1:0] mag_of(input logic [VALUE_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[VALUE_W-1], v};
    return v[VALUE_W-1] ? (~ext + MAG_W'(1)) : ext;
  endfunction

endpackage
`default_nettype wire

### rtl/tkm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkm_cell: one rank slot of the sorted chain
// Compares the broadcast candidate against its own entry, takes the candidate
// or the upper neighbor's entry on insert, and shifts toward slot 0 on readout.
// ----------------------------------------------------------------------------
module tkm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  tkm_pkg::cell_ctl_t        ctl,
  input  tkm_pkg::slot_t            cand,
  input  logic [tkm_pkg::MAG_W-1:0] cand_mag,
  input  logic [tkm_pkg::CFG_W-1:0] margin,
  input  tkm_pkg::slot_t            prev,
  input  tkm_pkg::slot_t            next,
  input  logic                      taken_in,
  output logic                      taken_out,
  output tkm_pkg::slot_t            held
);
  import tkm_pkg::*;

  logic [MAG_W-1:0] have_mag;
  logic [MAG_W:0]   diff;
  logic             win;

  assign have_mag = mag_of(held.value);
  assign diff     = {1'b0, cand_mag} - {1'b0, have_mag};
  // margin is non-negative, so diff > margin already implies cand > have
  assign win       = !diff[MAG_W] && (diff[MAG_W-1:0] > MAG_W'(margin));
  assign taken_out = taken_in || win;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctl.shift) begin
      held <= next;
    end else if (ctl.insert) begin
      if (taken_in) begin
        held <= prev;
      end else if (win) begin
        held <= cand;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/top_k_magnitude_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_magnitude_tracker: keeps the DEPTH largest-magnitude entries
// Insert places a candidate in a sorted chain of cells; readout streams the
// chain out through slot 0 and leaves it cleared.
// ----------------------------------------------------------------------------
//   channel  signals                          direction  moves
//   in       in_valid in_ready in_req         sink       insert / readout request
//   out      out_valid out_ready out_rsp      source     one slot per result
//   cfg      cfg_valid cfg_ready cfg_index    sink       register write
//            cfg_data
//
// Insert: all cells compare in parallel; a new request can follow at once while idle.
// Readout: one slot per cycle unless the output stalls, as the chain shifts toward slot 0;
//   no request is taken until the last slot has entered the output register.
// A stalled output register stalls the chain and holds off requests during readout;
//   inserts resume once the last slot is in the output register.
// Reset clears all slots and the fill count, sets the print threshold to 17 and the insert margin to 0.
// ----------------------------------------------------------------------------
module top_k_magnitude_tracker #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tkm_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tkm_pkg::out_rsp_t             out_rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tkm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tkm_pkg::CFG_W-1:0]     cfg_data
);
  import tkm_pkg::*;

  localparam int CNT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state;
  logic [CNT_W-1:0]  cnt;
  logic [FILL_W-1:0] fill;
  logic [CFG_W-1:0]  print_threshold;
  logic [CFG_W-1:0]  insert_margin;

  slot_t             held [DEPTH];
  logic [DEPTH:0]    taken;
  slot_t             cand;
  logic [MAG_W-1:0]  cand_mag;
  cell_ctl_t         ctl;
  logic              in_fire;
  logic              advance;
  logic              shown_next;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign advance   = (state == ST_READ) && (!out_valid || out_ready);

  assign cand.value = in_req.value;
  assign cand.row   = in_req.row_index;
  assign cand.col   = in_req.col_index;
  assign cand_mag   = mag_of(in_req.value);

  assign ctl.insert = in_fire && (in_req.cmd == CMD_INSERT);
  assign ctl.shift  = advance;
  assign taken[0]   = 1'b0;

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_cell
      slot_t prev_s;
      slot_t next_s;
      if (k == 0) begin : g_head
        assign prev_s = cand;
      end else begin : g_body
        assign prev_s = held[k-1];
      end
      if (k == DEPTH - 1) begin : g_tail
        assign next_s = '0;
      end else begin : g_inner
        assign next_s = held[k+1];
      end
      tkm_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .cand      (cand),
        .cand_mag  (cand_mag),
        .margin    (insert_margin),
        .prev      (prev_s),
        .next      (next_s),
        .taken_in  (taken[k]),
        .taken_out (taken[k+1]),
        .held      (held[k])
      );
    end
  endgenerate

  assign shown_next = (FILL_W'(cnt) < fill) &&
                      (mag_of(held[0].value) > MAG_W'(print_threshold));

  always_ff @(posedge clk) begin
    if (rst) begin
      print_threshold <= CFG_W'(17);
      insert_margin   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRINT_THRESHOLD: print_threshold <= cfg_data;
        REG_INSERT_MARGIN:   insert_margin   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_req.cmd == CMD_READOUT) begin
              state <= ST_READ;
              cnt   <= '0;
            end else if (fill != FULL) begin
              fill <= fill + FILL_W'(1);
            end
          end
        end
        ST_READ: begin
          if (advance) begin
            if (cnt == LAST_CNT) begin
              state <= ST_IDLE;
              fill  <= '0;
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp.value_out <= held[0].value;
      out_rsp.row_out   <= held[0].row;
      out_rsp.col_out   <= held[0].col;
      out_rsp.slot      <= SLOT_W'(cnt);
      out_rsp.shown     <= shown_next;
      out_rsp.last      <= (cnt == LAST_CNT);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count above DEPTH");

  a_read_start: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_req.cmd == CMD_READOUT) |=> (state == ST_READ) && (cnt == '0))
    else $error("readout request did not start at slot 0");

  a_read_end: assert property (@(posedge clk) disable iff (rst)
    advance && (cnt == LAST_CNT) |=> (state == ST_IDLE) && (fill == '0) && out_rsp.last)
    else $error("readout did not end cleanly");

  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && (out_rsp.slot == SLOT_W'($past(cnt))))
    else $error("result slot does not match readout counter");

  a_no_insert_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !ctl.insert)
    else $error("insert during readout");
`endif

endmodule
`default_nettype wire
